@@ hw/rtl/rbfsc_pkg.sv @@
// Package for the range bit flip/set counter.
// Holds the transaction structs, operation codes and fixed sizes.
// Has no dependencies.
package rbfsc_pkg;

    // Fixed geometry: 1024 positions kept as 32 words of 32 bits.
    localparam int unsigned Size      = 1024;
    localparam int unsigned WordBits  = 32;
    localparam int unsigned NumWords  = Size / WordBits;
    localparam int unsigned WordIdxW  = $clog2(NumWords);
    localparam int unsigned BitIdxW   = $clog2(WordBits);
    localparam int unsigned PosW      = $clog2(Size);
    localparam int unsigned CountW    = PosW + 1;
    localparam logic [CountW-1:0] PositionsReset = CountW'(Size);

    // Register index of positions_in_use.
    localparam logic RegPositions = 1'b0;

    typedef enum logic [1:0] {
        OP_QUERY = 2'd0,
        OP_FLIP  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_SET   = 2'd3
    } t_op;

    typedef logic [WordBits-1:0] t_word;

    typedef struct packed {
        logic [1:0]      operation;
        logic [PosW-1:0] range_low;
        logic [PosW-1:0] range_high;
    } t_cmd;

    typedef struct packed {
        logic [CountW-1:0] zero_count;
        logic [CountW-1:0] one_count;
        logic              range_error;
    } t_result;

endpackage

@@ hw/rtl/range_bit_flip_set_count.sv @@
// Top level of the range bit flip/set counter with its APB register port.
// Depends on rbfsc_pkg for types, operation codes and sizes.
// Timing: a well-formed item whose range spans W 32-bit words (1 to 32) keeps busy
// high while it walks those words, one word per cycle, through the shared word update
// and popcount unit; no new item is taken while busy is high. A query result strobes in
// the cycle after the last word. A malformed item leaves busy low; a malformed query
// strobes its error in the cycle after it is taken.
// Reset and any write of positions_in_use clear all positions. The receiver cannot stall.
module range_bit_flip_set_count (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rbfsc_pkg::t_cmd      i_cmd,
    output logic                 o_result_valid,
    output rbfsc_pkg::t_result   o_result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state r_state, n_state;
    rbfsc_pkg::t_word r_bits [rbfsc_pkg::NumWords];
    logic [rbfsc_pkg::CountW-1:0]   r_positions;
    logic [rbfsc_pkg::WordIdxW-1:0] r_word, n_word;
    logic [1:0]                     r_op;
    logic [rbfsc_pkg::PosW-1:0]     r_lo, r_hi;
    logic [rbfsc_pkg::CountW-1:0]   r_ones, n_ones;
    logic                           r_valid, n_valid;
    rbfsc_pkg::t_result             r_result, n_result;

    logic                           cfg_write;
    logic [10:0]                    cfg_value;
    logic [rbfsc_pkg::CountW-1:0]   cfg_clamped;
    logic                           accept;
    logic                           bad_range;
    rbfsc_pkg::t_word               mask_lo, mask_hi, mask, cur_word, new_word;
    logic                           is_last;
    logic [rbfsc_pkg::CountW-1:0]   span;

    // Register port: always ready, one register at index zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_value = pwdata[10:0];
    always_comb begin
        priority if (cfg_value == 11'd0) begin
            cfg_clamped = rbfsc_pkg::CountW'(1);
        end else if (cfg_value > rbfsc_pkg::PositionsReset) begin
            cfg_clamped = rbfsc_pkg::PositionsReset;
        end else begin
            cfg_clamped = cfg_value;
        end
    end
    assign prdata = (paddr[2] == rbfsc_pkg::RegPositions)
                  ? {{(32 - rbfsc_pkg::CountW){1'b0}}, r_positions} : 32'd0;

    // Command acceptance and range check.
    assign busy      = (r_state == ST_RUN);
    assign accept    = start && !busy;
    assign bad_range = (i_cmd.range_low > i_cmd.range_high)
                    || ({1'b0, i_cmd.range_high} >= r_positions);

    // Mask of the positions of the current word that lie inside the range.
    assign cur_word = r_bits[r_word];
    assign mask_lo  = (r_word == r_lo[rbfsc_pkg::PosW-1 -: rbfsc_pkg::WordIdxW])
                    ? ('1 << r_lo[rbfsc_pkg::BitIdxW-1:0]) : '1;
    assign mask_hi  = (r_word == r_hi[rbfsc_pkg::PosW-1 -: rbfsc_pkg::WordIdxW])
                    ? ('1 >> (rbfsc_pkg::BitIdxW'(rbfsc_pkg::WordBits - 1)
                              - r_hi[rbfsc_pkg::BitIdxW-1:0])) : '1;
    assign mask     = mask_lo & mask_hi;
    assign is_last  = (r_word == r_hi[rbfsc_pkg::PosW-1 -: rbfsc_pkg::WordIdxW]);
    assign span     = rbfsc_pkg::CountW'(r_hi) - rbfsc_pkg::CountW'(r_lo)
                    + rbfsc_pkg::CountW'(1);

    // Shared word unit: update the masked bits or count the ones among them.
    always_comb begin
        unique case (r_op)
            rbfsc_pkg::OP_FLIP:  new_word = cur_word ^ mask;
            rbfsc_pkg::OP_CLEAR: new_word = cur_word & ~mask;
            rbfsc_pkg::OP_SET:   new_word = cur_word | mask;
            default:             new_word = cur_word;
        endcase
    end
    assign n_ones = r_ones + rbfsc_pkg::CountW'($countones(cur_word & mask));

    // Sequencer: walk the words from the low end to the high end.
    always_comb begin
        n_state  = r_state;
        n_word   = r_word;
        n_valid  = 1'b0;
        n_result = r_result;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_word = i_cmd.range_low[rbfsc_pkg::PosW-1 -: rbfsc_pkg::WordIdxW];
                    if (bad_range) begin
                        if (i_cmd.operation == rbfsc_pkg::OP_QUERY) begin
                            n_valid  = 1'b1;
                            n_result = '{zero_count: '0, one_count: '0, range_error: 1'b1};
                        end
                    end else begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                n_word = r_word + rbfsc_pkg::WordIdxW'(1);
                if (is_last) begin
                    n_state = ST_IDLE;
                    if (r_op == rbfsc_pkg::OP_QUERY) begin
                        n_valid  = 1'b1;
                        n_result = '{zero_count: span - n_ones, one_count: n_ones,
                                     range_error: 1'b0};
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state and position store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= 1'b0;
            r_positions <= rbfsc_pkg::PositionsReset;
            for (int i = 0; i < rbfsc_pkg::NumWords; i++) begin
                r_bits[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (cfg_write && paddr[2] == rbfsc_pkg::RegPositions) begin
                r_positions <= cfg_clamped;
                for (int i = 0; i < rbfsc_pkg::NumWords; i++) begin
                    r_bits[i] <= '0;
                end
            end else if (r_state == ST_RUN) begin
                r_bits[r_word] <= new_word;
            end
        end
    end

    // Item registers and result payload.
    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_result <= n_result;
        if (accept) begin
            r_op   <= i_cmd.operation;
            r_lo   <= i_cmd.range_low;
            r_hi   <= i_cmd.range_high;
            r_ones <= '0;
        end else if (r_state == ST_RUN) begin
            r_ones <= n_ones;
        end
    end

    assign o_result_valid = r_valid;
    assign o_result       = r_result;

endmodule
